// ===== hw/rtl/tcgr_pkg.sv =====
// Shared constants, types and the fixed colour palette for the text cell glyph renderer.
// Used by tcgr_font_store, tcgr_pixel_serialiser and text_cell_glyph_renderer_core.
package tcgr_pkg;

  localparam int CELL_WIDTH  = 8;
  localparam int LINES_PER_GLYPH = 16;
  localparam int GLYPH_COUNT = 256;

  localparam int STORE_DEPTH = GLYPH_COUNT * LINES_PER_GLYPH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CODE_W      = 8;
  localparam int LINE_W      = 4;
  localparam int ATTR_W      = 8;
  localparam int OFFSET_W    = $clog2(CELL_WIDTH);
  localparam int COLOUR_W    = 24;
  localparam int PAL_IDX_W   = 4;

  localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(CELL_WIDTH - 1);

  // operation codes (tuser bit 0)
  localparam logic OP_FONT_WRITE = 1'b0;
  localparam logic OP_RENDER     = 1'b1;

  // font banks
  localparam logic BANK_PRIMARY   = 1'b0;
  localparam logic BANK_SECONDARY = 1'b1;

  // attribute bit that picks the secondary font
  localparam int ATTR_FONT_BIT = 3;

  typedef logic [CELL_WIDTH-1:0] glyph_row_t;
  typedef logic [COLOUR_W-1:0]   colour_t;

  // one scan line of a cell, handed to the serialiser
  typedef struct packed {
    glyph_row_t          glyph_bits;
    logic [ATTR_W-1:0]   cell_attribute;
  } cell_line_t;

  // red in 7:0, green in 15:8, blue in 23:16
  localparam colour_t PALETTE [16] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
    24'h0000AA, 24'hAA00AA, 24'h0055AA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
  };

endpackage

// ===== hw/rtl/tcgr_font_store.sv =====
// Primary and secondary font memories, one write and one registered read per cycle.
// Depends on tcgr_pkg.
module tcgr_font_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic                      wr_bank,
  input  logic [tcgr_pkg::ADDR_W-1:0] wr_addr,
  input  tcgr_pkg::glyph_row_t      wr_data,
  input  logic                      rd_en,
  input  logic                      rd_bank,
  input  logic [tcgr_pkg::ADDR_W-1:0] rd_addr,
  output tcgr_pkg::glyph_row_t      rd_data
);
  import tcgr_pkg::*;

  glyph_row_t primary_mem   [STORE_DEPTH];
  glyph_row_t secondary_mem [STORE_DEPTH];
  glyph_row_t primary_q;
  glyph_row_t secondary_q;
  logic       bank_q;

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank == BANK_PRIMARY) begin
      primary_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      primary_q <= primary_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank == BANK_SECONDARY) begin
      secondary_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      secondary_q <= secondary_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      bank_q <= rd_bank;
    end
  end

  assign rd_data = (bank_q == BANK_SECONDARY) ? secondary_q : primary_q;

endmodule

// ===== hw/rtl/tcgr_pixel_serialiser.sv =====
// Turns one glyph scan line into eight palette pixels, one item per cycle while pix_ready is high, MSB first.
// Depends on tcgr_pkg.
module tcgr_pixel_serialiser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tcgr_pkg::cell_line_t line,
  output logic                 load_ready,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output tcgr_pkg::colour_t    pix_colour,
  output logic [tcgr_pkg::OFFSET_W-1:0] pix_offset,
  output logic                 pix_last
);
  import tcgr_pkg::*;

  logic                busy;
  logic [OFFSET_W-1:0] idx;
  glyph_row_t          bits;
  colour_t             fg;
  colour_t             bg;

  assign load_ready = !busy || (pix_ready && idx == LAST_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
      bits <= line.glyph_bits;
      fg   <= PALETTE[line.cell_attribute[PAL_IDX_W-1:0]];
      bg   <= PALETTE[line.cell_attribute[ATTR_W-1:PAL_IDX_W]];
    end else if (busy && pix_ready) begin
      if (idx == LAST_OFFSET) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx  <= idx + OFFSET_W'(1);
        bits <= bits << 1;
      end
    end
  end

  assign pix_valid  = busy;
  assign pix_colour = bits[CELL_WIDTH-1] ? fg : bg;
  assign pix_offset = idx;
  assign pix_last   = (idx == LAST_OFFSET);

`ifndef NO_ASSERTIONS
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && idx == '0)
    else $error("serialiser did not restart at offset zero");

  a_step: assert property (@(posedge clk) disable iff (rst)
    busy && pix_ready && idx != LAST_OFFSET |=> busy && idx == $past(idx) + OFFSET_W'(1))
    else $error("pixel offset did not advance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !pix_ready |=> busy && $stable(idx) && $stable(bits))
    else $error("stalled pixel changed");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !busy |-> idx == '0)
    else $error("idle serialiser holds a non-zero offset");
`endif

endmodule

// ===== hw/rtl/text_cell_glyph_renderer_core.sv =====
// Text cell glyph renderer top level: input decode, font store and pixel serialiser.
// Depends on tcgr_pkg, tcgr_font_store and tcgr_pixel_serialiser.
//
// A font-write item gives no output; a render item gives eight pixel items, one per cycle
// while m_axis_tready is high. The font memory is read at the accepting edge, the line
// waits in the read stage until the serialiser is ready to load it, and the first pixel
// is offered from the serialiser's registers after it has loaded the line. The next
// item is accepted into the read stage while the serialiser's current line is
// still being shifted out. Font memories are not cleared at reset: render only glyph lines
// already written. A write followed at once by a render of the same entry reads the new byte.
module text_cell_glyph_renderer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: bit 0 attr_font_select_enable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // glyph_code[7:0], scan_line[11:8], glyph_bits[19:12], cell_attribute[27:20], zero[31:28]
  input  logic [31:0] s_axis_tdata,
  // operation[0], font_bank[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_colour[23:0], pixel_offset[26:24], zero[31:27]
  output logic [31:0] m_axis_tdata,
  // last_pixel
  output logic        m_axis_tlast
);
  import tcgr_pkg::*;

  logic font_sel_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_sel_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      font_sel_en <= cfg_data;
    end
  end

  // input decode
  logic               in_op;
  logic               in_bank;
  logic [CODE_W-1:0]  in_code;
  logic [LINE_W-1:0]  in_line;
  glyph_row_t         in_bits;
  logic [ATTR_W-1:0]  in_attr;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_line_ok;
  logic               accept;

  assign in_op   = s_axis_tuser[0];
  assign in_bank = s_axis_tuser[1];
  assign in_code = s_axis_tdata[7:0];
  assign in_line = s_axis_tdata[11:8];
  assign in_bits = s_axis_tdata[19:12];
  assign in_attr = s_axis_tdata[27:20];

  assign in_addr    = ADDR_W'(in_code) * ADDR_W'(LINES_PER_GLYPH) + ADDR_W'(in_line);
  assign in_line_ok = (32'(in_line) < LINES_PER_GLYPH);
  assign accept     = s_axis_tvalid && s_axis_tready;

  // read stage
  logic              s1_valid;
  logic              s1_render;
  logic              s1_ok;
  logic [ATTR_W-1:0] s1_attr;
  logic              s1_adv;
  logic              load_ready;
  logic              load;
  glyph_row_t        rd_data;
  cell_line_t        line;

  tcgr_font_store u_font_store (
    .clk     (clk),
    .wr_en   (accept && in_op == OP_FONT_WRITE && in_line_ok),
    .wr_bank (in_bank),
    .wr_addr (in_addr),
    .wr_data (in_bits),
    .rd_en   (accept && in_op == OP_RENDER),
    .rd_bank (font_sel_en && in_attr[ATTR_FONT_BIT]),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  assign load          = s1_valid && s1_render && load_ready;
  assign s1_adv        = s1_valid && (!s1_render || load_ready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (accept) begin
      s1_render <= (in_op == OP_RENDER);
      s1_ok     <= in_line_ok;
      s1_attr   <= in_attr;
    end
  end

  assign line = '{glyph_bits: (s1_ok ? rd_data : '0), cell_attribute: s1_attr};

  colour_t             pix_colour;
  logic [OFFSET_W-1:0] pix_offset;

  tcgr_pixel_serialiser u_serialiser (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .line       (line),
    .load_ready (load_ready),
    .pix_valid  (m_axis_tvalid),
    .pix_ready  (m_axis_tready),
    .pix_colour (pix_colour),
    .pix_offset (pix_offset),
    .pix_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, pix_offset, pix_colour};

endmodule
